// ===== rtl/s_expression_token_scanner_assert.svh =====
// Assertion macros used by the checker file.
`ifndef S_EXPRESSION_TOKEN_SCANNER_ASSERT_SVH
`define S_EXPRESSION_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SEXP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sexp scanner check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sexp scanner check failed");

`endif

// ===== rtl/sexp_pkg.sv =====
package sexp_pkg;

  localparam int POS_BITS = 16;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    KIND_OPEN   = 3'd0,
    KIND_CLOSE  = 3'd1,
    KIND_STRING = 3'd2,
    KIND_ATOM   = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] length;
    logic [15:0] row;
    logic [15:0] column;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } core_out_t;

endpackage

// ===== rtl/sexp_in_if.sv =====
interface sexp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// ===== rtl/sexp_out_if.sv =====
interface sexp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] start_offset;
  logic [15:0] length;
  logic [15:0] row;
  logic [15:0] column;
  logic        last;

  modport source (output valid, output kind, output start_offset, output length,
                  output row, output column, output last, input ready);
  modport sink (input valid, input kind, input start_offset, input length,
                input row, input column, input last, output ready);
endinterface

// ===== rtl/sexp_scan_core.sv =====
module sexp_scan_core
  import sexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] ch,
  output core_out_t  res
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = pos_t'(1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_ATOM
  } mode_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [15:0] clamp16(pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic result_t mk_res(kind_t k, pos_t start, pos_t len, pos_t r, pos_t c);
    result_t t;
    t.kind         = k;
    t.start_offset = clamp16(start);
    t.length       = clamp16(len);
    t.row          = clamp16(r);
    t.column       = clamp16(c);
    t.last         = 1'b0;
    return t;
  endfunction

  mode_t mode_r, mode_nxt;
  pos_t  offset_r, offset_nxt;
  pos_t  row_r, row_nxt;
  pos_t  col_r, col_nxt;
  pos_t  tok_start_r, tok_start_nxt;
  pos_t  tok_row_r, tok_row_nxt;
  pos_t  tok_col_r, tok_col_nxt;

  logic    is_nul, is_nl, is_blank, is_paren;
  logic    run_idle, ended;
  logic    pre_valid, post_valid;
  result_t pre_res, post_res;
  pos_t    span;

  assign is_nul   = (ch == CH_NUL);
  assign is_nl    = (ch == CH_NL);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_COMMA) || is_nl;
  assign is_paren = (ch == CH_LPAREN) || (ch == CH_RPAREN);
  assign span     = offset_r - tok_start_r;

  always_comb begin
    mode_nxt      = mode_r;
    tok_start_nxt = tok_start_r;
    tok_row_nxt   = tok_row_r;
    tok_col_nxt   = tok_col_r;
    run_idle      = 1'b0;
    ended         = 1'b0;
    pre_valid     = 1'b0;
    post_valid    = 1'b0;
    pre_res       = mk_res(KIND_STRING, tok_start_r, span, tok_row_r, tok_col_r);
    post_res      = mk_res(KIND_END, offset_r, '0, row_r, col_r);

    case (mode_r)
      MODE_COMMENT: begin
        run_idle = is_nul || is_nl;
      end
      MODE_STRING, MODE_ESCAPE: begin
        if (is_nul) begin
          pre_valid = 1'b1;
          run_idle  = 1'b1;
        end else if (mode_r == MODE_ESCAPE) begin
          mode_nxt = MODE_STRING;
        end else if (ch == CH_QUOTE) begin
          pre_valid = 1'b1;
          pre_res   = mk_res(KIND_STRING, tok_start_r, sat_inc(span), tok_row_r, tok_col_r);
          mode_nxt  = MODE_IDLE;
        end else if (ch == CH_BSLASH) begin
          mode_nxt = MODE_ESCAPE;
        end
      end
      MODE_ATOM: begin
        if (is_nul || is_blank || is_paren) begin
          pre_valid = 1'b1;
          pre_res   = mk_res(KIND_ATOM, tok_start_r, span, tok_row_r, tok_col_r);
          run_idle  = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      mode_nxt = MODE_IDLE;
      if (is_nul) begin
        post_valid = 1'b1;
        ended      = 1'b1;
      end else if (is_blank) begin
        mode_nxt = MODE_IDLE;
      end else if (ch == CH_SEMI) begin
        mode_nxt = MODE_COMMENT;
      end else if (is_paren) begin
        post_valid = 1'b1;
        post_res   = mk_res((ch == CH_LPAREN) ? KIND_OPEN : KIND_CLOSE, offset_r, POS_ONE,
                            row_r, col_r);
      end else begin
        tok_start_nxt = offset_r;
        tok_row_nxt   = row_r;
        tok_col_nxt   = col_r;
        mode_nxt      = (ch == CH_QUOTE) ? MODE_STRING : MODE_ATOM;
      end
    end

    if (ended) begin
      offset_nxt = '0;
      row_nxt    = POS_ONE;
      col_nxt    = POS_ONE;
    end else begin
      offset_nxt = sat_inc(offset_r);
      row_nxt    = is_nl ? sat_inc(row_r) : row_r;
      col_nxt    = is_nl ? POS_ONE : sat_inc(col_r);
    end

    res.count       = {1'b0, pre_valid} + {1'b0, post_valid};
    res.first       = pre_valid ? pre_res : post_res;
    res.first.last  = !(pre_valid && post_valid);
    res.second      = post_res;
    res.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      offset_r    <= '0;
      row_r       <= POS_ONE;
      col_r       <= POS_ONE;
      tok_start_r <= '0;
      tok_row_r   <= POS_ONE;
      tok_col_r   <= POS_ONE;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      offset_r    <= offset_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      tok_start_r <= tok_start_nxt;
      tok_row_r   <= tok_row_nxt;
      tok_col_r   <= tok_col_nxt;
    end
  end

endmodule

// ===== rtl/s_expression_token_scanner.sv =====
// Channel  Dir  Payload                                         Handshake
// in_bus   in   ch[7:0]                                         valid/ready
// out_bus  out  kind, start_offset, length, row, column, last   valid/ready
//
// One source byte is taken every cycle while in_bus.ready is high; it is held in the
// input register and scanned once the queue has room. A byte yields zero, one or two
// tokens, written into a four-entry result queue. The queue drains one token a cycle
// while out_bus.ready is high, so bytes that yield two tokens back to back are paced by the queue drain port.
// Synchronous active-low reset returns to the start of source.
// Input ready drops only while the input register is full and the queue lacks
// room for two tokens.
module s_expression_token_scanner
  import sexp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  sexp_in_if.sink   in_bus,
  sexp_out_if.source out_bus
);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  logic            in_valid_r;
  logic [7:0]      in_ch_r;
  logic            proc;
  logic            in_take;
  logic            pop;
  core_out_t       core_res;
  logic [1:0]      push_n;
  result_t         q_r [Q_DEPTH];
  logic [Q_AW-1:0] head_r, tail_r, tail_p1;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  result_t         head_res;

  assign proc    = in_valid_r && (cnt_r <= Q_CW'(Q_DEPTH - 2));
  assign in_take = in_bus.valid && in_bus.ready;
  assign in_bus.ready = !in_valid_r || proc;

  sexp_scan_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (proc),
    .ch    (in_ch_r),
    .res   (core_res)
  );

  assign push_n  = proc ? core_res.count : 2'd0;
  assign pop     = out_bus.valid && out_bus.ready;
  assign tail_p1 = tail_r + Q_AW'(1);
  assign cnt_nxt = cnt_r + Q_CW'(push_n) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_ch_r <= in_bus.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= pop ? head_r + Q_AW'(1) : head_r;
      tail_r <= tail_r + Q_AW'(push_n);
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[tail_r] <= core_res.first;
    end
    if (push_n == 2'd2) begin
      q_r[tail_p1] <= core_res.second;
    end
  end

  assign head_res             = q_r[head_r];
  assign out_bus.valid        = (cnt_r != '0);
  assign out_bus.kind         = head_res.kind;
  assign out_bus.start_offset = head_res.start_offset;
  assign out_bus.length       = head_res.length;
  assign out_bus.row          = head_res.row;
  assign out_bus.column       = head_res.column;
  assign out_bus.last         = head_res.last;

endmodule

// ===== rtl/sexp_checker.sv =====
`include "s_expression_token_scanner_assert.svh"

module sexp_checker
  import sexp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [15:0] out_start_offset,
  input logic [15:0] out_length,
  input logic [15:0] out_row,
  input logic [15:0] out_column,
  input logic        out_last
);

  `SEXP_ASSERT_NOW(a_end_len, out_valid && out_kind == KIND_END, out_length == 16'd0 && out_last)
  `SEXP_ASSERT_NOW(a_paren_len, out_valid && (out_kind == KIND_OPEN || out_kind == KIND_CLOSE), out_length == 16'd1 && out_last)
  `SEXP_ASSERT_NOW(a_pos_nonzero, out_valid, out_row != 16'd0 && out_column != 16'd0)
  `SEXP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_start_offset) && $stable(out_length) && $stable(out_row) && $stable(out_column) && $stable(out_last))

endmodule

bind s_expression_token_scanner sexp_checker u_sexp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_kind         (out_bus.kind),
  .out_start_offset (out_bus.start_offset),
  .out_length       (out_bus.length),
  .out_row          (out_bus.row),
  .out_column       (out_bus.column),
  .out_last         (out_bus.last)
);
